/* design/pbd_pkg.sv */
// Package for the PackBits pixel decoder: beat payload types, phase codes
// and configuration register indexes. No dependencies.
package pbd_pkg;

  // Input beat: one byte of the compressed stream
  typedef struct packed {
    logic [7:0] source_byte;
    logic       start_req;
  } pbd_in_t;

  // Result beat: one pixel write (literal or run), an error or an image end
  typedef struct packed {
    logic [15:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic        overflow_error;
    logic [17:0] bytes_consumed;
  } pbd_out_t;

  // Decoder phase codes
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LIT8   = 3'd1;
  localparam logic [2:0] PH_LIT_HI = 3'd2;
  localparam logic [2:0] PH_LIT_LO = 3'd3;
  localparam logic [2:0] PH_RUN8   = 3'd4;
  localparam logic [2:0] PH_RUN_HI = 3'd5;
  localparam logic [2:0] PH_RUN_LO = 3'd6;

  // Configuration register indexes and port widths
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_MODE  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEST_PIXELS = 1'd1;

endpackage

/* design/packbits_pixel_decoder_core.sv */
// Top level of the PackBits pixel decoder: byte decoder plus result buffer.
// Depends on pbd_pkg, pbd_decode and pbd_out_buf.
//
//   port group | direction | handshake         | payload
//   in_        | in        | in_valid/in_ready | pbd_in_t  (source_byte, start_req)
//   out_       | out       | out_valid/ready   | pbd_out_t (pixel, count, done, error, bytes)
//   cfg_       | in        | cfg_we            | cfg_addr, cfg_wdata
//
// One source byte is accepted per cycle while in_ready is high; its result, if any,
// appears on out_ in the cycle after acceptance while out_ is not stalled. The decode
// is one pass of logic from the input beat into the result register. A stalled output
// parks one extra result in the skid stage; in_ready drops only while that
// stage is full. Reset (rst_n, synchronous) idles the decoder until a byte
// with start_req arrives.
module packbits_pixel_decoder_core import pbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pbd_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pbd_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic     in_fire;
  logic     res_valid;
  pbd_out_t res_beat;

  assign in_fire = in_valid && in_ready;

  // Per-byte decode and state
  pbd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_beat   (in_data),
    .res_valid (res_valid),
    .res_beat  (res_beat)
  );

  // Result register and skid stage
  pbd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_beat (res_beat),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* design/pbd_decode.sv */
// Decoder state and per-byte next-state logic for the PackBits pixel decoder.
// Holds the configuration registers. Depends on pbd_pkg.
module pbd_decode import pbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_fire,
  input  pbd_in_t               in_beat,
  output logic                  res_valid,
  output pbd_out_t              res_beat
);

  logic        pixel_mode_r;
  logic [15:0] dest_pixels_r;

  logic [2:0]  phase_r,    phase_nxt;
  logic [7:0]  pkt_rem_r,  pkt_rem_nxt;
  logic [15:0] pix_left_r, pix_left_nxt;
  logic [7:0]  hi_hold_r,  hi_hold_nxt;
  logic [17:0] byte_cnt_r, byte_cnt_nxt;
  logic        active_r,   active_nxt;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r  <= 1'b0;
      dest_pixels_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PIXEL_MODE:  pixel_mode_r  <= cfg_wdata[0];
        CFG_DEST_PIXELS: dest_pixels_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Decode one source byte
  always_comb begin
    logic [7:0]  b;
    logic [7:0]  n;
    logic        give_en;
    logic [15:0] give_pix;
    logic [7:0]  give_cnt;
    logic [15:0] left;

    b            = in_beat.source_byte;
    n            = 8'd0;
    give_en      = 1'b0;
    give_pix     = 16'd0;
    give_cnt     = 8'd0;
    left         = 16'd0;
    phase_nxt    = phase_r;
    pkt_rem_nxt  = pkt_rem_r;
    pix_left_nxt = pix_left_r;
    hi_hold_nxt  = hi_hold_r;
    byte_cnt_nxt = byte_cnt_r;
    active_nxt   = active_r;
    res_valid    = 1'b0;
    res_beat     = '0;

    if (in_fire) begin
      // Restart on a start flag; an empty image finishes at once
      if (in_beat.start_req) begin
        active_nxt   = 1'b1;
        phase_nxt    = PH_HEADER;
        pkt_rem_nxt  = 8'd0;
        hi_hold_nxt  = 8'd0;
        byte_cnt_nxt = 18'd0;
        pix_left_nxt = dest_pixels_r;
        if (dest_pixels_r == 16'd0) begin
          active_nxt          = 1'b0;
          res_valid           = 1'b1;
          res_beat.image_done = 1'b1;
        end
      end

      if (active_nxt) begin
        byte_cnt_nxt = byte_cnt_nxt + 18'd1;
        case (phase_nxt)
          PH_HEADER: begin
            n = b[7] ? (~b + 8'd2) : (b + 8'd1);
            if ({8'd0, n} > pix_left_nxt) begin
              active_nxt              = 1'b0;
              phase_nxt               = PH_HEADER;
              pkt_rem_nxt             = 8'd0;
              res_valid               = 1'b1;
              res_beat.overflow_error = 1'b1;
            end else begin
              pkt_rem_nxt = n;
              if (pixel_mode_r) phase_nxt = b[7] ? PH_RUN_HI : PH_LIT_HI;
              else              phase_nxt = b[7] ? PH_RUN8   : PH_LIT8;
            end
          end
          PH_LIT8: begin
            pkt_rem_nxt = pkt_rem_nxt - 8'd1;
            give_en     = 1'b1;
            give_pix    = {8'd0, b};
            give_cnt    = 8'd1;
          end
          PH_LIT_HI: begin
            hi_hold_nxt = b;
            phase_nxt   = PH_LIT_LO;
          end
          PH_LIT_LO: begin
            pkt_rem_nxt = pkt_rem_nxt - 8'd1;
            phase_nxt   = PH_LIT_HI;
            give_en     = 1'b1;
            give_pix    = {hi_hold_nxt, b};
            give_cnt    = 8'd1;
          end
          PH_RUN8: begin
            give_en     = 1'b1;
            give_pix    = {8'd0, b};
            give_cnt    = pkt_rem_nxt;
            pkt_rem_nxt = 8'd0;
          end
          PH_RUN_HI: begin
            hi_hold_nxt = b;
            phase_nxt   = PH_RUN_LO;
          end
          PH_RUN_LO: begin
            give_en     = 1'b1;
            give_pix    = {hi_hold_nxt, b};
            give_cnt    = pkt_rem_nxt;
            pkt_rem_nxt = 8'd0;
          end
          default: phase_nxt = PH_HEADER;
        endcase

        // Write pixels; close the image or the packet when used up
        if (give_en) begin
          left                  = pix_left_nxt - {8'd0, give_cnt};
          pix_left_nxt          = left;
          res_valid             = 1'b1;
          res_beat.pixel_value  = give_pix;
          res_beat.repeat_count = give_cnt;
          if (left == 16'd0) begin
            active_nxt              = 1'b0;
            phase_nxt               = PH_HEADER;
            pkt_rem_nxt             = 8'd0;
            res_beat.image_done     = 1'b1;
            res_beat.bytes_consumed = byte_cnt_nxt;
          end else if (pkt_rem_nxt == 8'd0) begin
            phase_nxt = PH_HEADER;
          end
        end
      end
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pkt_rem_r  <= 8'd0;
      pix_left_r <= 16'd0;
      hi_hold_r  <= 8'd0;
      byte_cnt_r <= 18'd0;
      active_r   <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      pkt_rem_r  <= pkt_rem_nxt;
      pix_left_r <= pix_left_nxt;
      hi_hold_r  <= hi_hold_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      active_r   <= active_nxt;
    end
  end

`ifndef SYNTHESIS
  // Idle decoder always waits on a fresh header
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (phase_r == PH_HEADER && pkt_rem_r == 8'd0))
    else $error("idle decoder left a packet open");

  // An active image still has pixels to fill
  a_active_left: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> pix_left_r != 16'd0)
    else $error("active image with no pixels left");

  // Inside a packet the packet count is never exhausted
  a_pkt_open: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && phase_r != PH_HEADER) |-> pkt_rem_r != 8'd0)
    else $error("packet phase with zero remaining");
`endif

endmodule

/* design/pbd_out_buf.sv */
// Result register with skid stage for the PackBits pixel decoder.
// Depends on pbd_pkg.
module pbd_out_buf import pbd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pbd_out_t push_beat,
  output logic     can_push,
  output logic     out_valid,
  input  logic     out_ready,
  output pbd_out_t out_data
);

  logic     main_valid_r;
  pbd_out_t main_r;
  logic     skid_valid_r;
  pbd_out_t skid_r;
  logic     main_free;

  assign can_push  = !skid_valid_r;
  assign main_free = !main_valid_r || out_ready;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      main_valid_r <= skid_valid_r || push;
      skid_valid_r <= skid_valid_r && push;
    end else begin
      skid_valid_r <= skid_valid_r || push;
    end
  end

  // Payload: skid moves to main; a new beat queues behind any held beat
  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
        if (push) skid_r <= push_beat;
      end else if (push) begin
        main_r <= push_beat;
      end
    end else if (push) begin
      skid_r <= push_beat;
    end
  end

`ifndef SYNTHESIS
  // Skid only fills behind a held result
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry without main entry");

  // Stalled output keeps its beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // A skid beat survives until the main slot drains
  a_skid_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> (skid_valid_r && $stable(skid_r)))
    else $error("skid beat lost under stall");
`endif

endmodule
